### sv/olid_pkg.sv
// Shared types and constants for the ordered list block.
// Used by olid_cell, olid_enc and the top level ordered_list_insert_delete_find.
package olid_pkg;

    localparam int DEPTH       = 64;
    localparam int VALUE_WIDTH = 32;

    // Fixed field widths of the request and result ports.
    localparam int REQ_W   = 3;
    localparam int POS_W   = 7;
    localparam int STAT_W  = 2;
    localparam int FOUND_W = 6;
    localparam int ENTRY_W = 7;

    // Internal widths derived from the list depth.
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int GRP_SZ  = 8;
    localparam int LOC_W   = 3;
    localparam int NGRP    = (DEPTH + GRP_SZ - 1) / GRP_SZ;
    localparam int GRP_W   = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int PAD_W   = NGRP * GRP_SZ;

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND = 3'd0,
        REQ_INSERT = 3'd1,
        REQ_DELETE = 3'd2,
        REQ_FIND   = 3'd3,
        REQ_CLEAR  = 3'd4
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_POS   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        C_HOLD,
        C_APPEND,
        C_INSERT,
        C_DELETE,
        C_FIND
    } t_cell_op;

    typedef struct packed {
        t_cell_op               op;
        logic [CMP_W-1:0]       pos;
        logic [CNT_W-1:0]       count;
        logic [VALUE_WIDTH-1:0] value;
    } t_cell_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_GROUP,
        S_PICK,
        S_OUT
    } t_state;

endpackage

### sv/ordered_list_insert_delete_find.sv
// Ordered list of up to 64 signed 32-bit entries held in a row of cells, one entry
// per cell. The block works on one request at a time: append, insert, delete and
// clear pass through the execute and output states before a valid result, and find
// also passes the group and pick states because the match bits go through a
// two-stage priority encoder. o_in_stall is high while a request is in progress; a
// finished result waits in the output register, so the next request may be accepted
// while that result is still stalled downstream. A new request is not accepted until
// the last one has reached the output register; a result that finds the output
// register still stalled holds the block until that register frees up.
// Depends on olid_pkg, olid_cell and olid_enc.
module ordered_list_insert_delete_find (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [olid_pkg::REQ_W-1:0]      i_req_type,
    input  logic [olid_pkg::POS_W-1:0]      i_position,
    input  logic signed [olid_pkg::VALUE_WIDTH-1:0] i_item_value,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [olid_pkg::STAT_W-1:0]     o_status,
    output logic [olid_pkg::FOUND_W-1:0]    o_found_position,
    output logic [olid_pkg::ENTRY_W-1:0]    o_entry_count
);

    olid_pkg::t_state                  r_state;
    olid_pkg::t_state                  n_state;
    logic [olid_pkg::REQ_W-1:0]        r_req;
    logic [olid_pkg::POS_W-1:0]        r_pos;
    logic [olid_pkg::VALUE_WIDTH-1:0]  r_val;
    logic [olid_pkg::CNT_W-1:0]        r_count;
    logic [olid_pkg::CNT_W-1:0]        n_count;
    olid_pkg::t_status                 r_res_status;
    olid_pkg::t_status                 n_res_status;
    logic [olid_pkg::FOUND_W-1:0]      r_res_found;
    logic [olid_pkg::FOUND_W-1:0]      n_res_found;
    logic                              r_out_valid;
    logic                              n_out_valid;
    olid_pkg::t_status                 r_out_status;
    olid_pkg::t_status                 n_out_status;
    logic [olid_pkg::FOUND_W-1:0]      r_out_found;
    logic [olid_pkg::FOUND_W-1:0]      n_out_found;
    logic [olid_pkg::CNT_W-1:0]        r_out_count;
    logic [olid_pkg::CNT_W-1:0]        n_out_count;

    olid_pkg::t_cell_cmd               w_cmd;
    logic [olid_pkg::CMP_W-1:0]        w_pos;
    logic [olid_pkg::CMP_W-1:0]        w_cnt;
    logic                              w_full;
    logic                              w_accept;
    logic [olid_pkg::VALUE_WIDTH-1:0]  w_value [olid_pkg::DEPTH];
    logic [olid_pkg::DEPTH-1:0]        w_match;
    logic                              w_hit;
    logic [olid_pkg::IDX_W-1:0]        w_hit_index;

    assign o_in_stall = (r_state != olid_pkg::S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_pos      = olid_pkg::CMP_W'(r_pos);
    assign w_cnt      = olid_pkg::CMP_W'(r_count);
    assign w_full     = (r_count == olid_pkg::CNT_W'(olid_pkg::DEPTH));

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_count  = r_out_count;
        w_cmd.op     = olid_pkg::C_HOLD;
        w_cmd.pos    = w_pos;
        w_cmd.count  = r_count;
        w_cmd.value  = r_val;

        unique case (r_state)
            olid_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = olid_pkg::S_EXEC;
                end
            end
            olid_pkg::S_EXEC: begin
                n_res_status = olid_pkg::ST_OK;
                n_res_found  = '0;
                n_state      = olid_pkg::S_OUT;
                unique case (r_req)
                    olid_pkg::REQ_APPEND: begin
                        if (w_full) begin
                            n_res_status = olid_pkg::ST_FULL;
                        end else begin
                            w_cmd.op = olid_pkg::C_APPEND;
                            n_count  = r_count + 1'b1;
                        end
                    end
                    olid_pkg::REQ_INSERT: begin
                        if (w_pos > w_cnt) begin
                            n_res_status = olid_pkg::ST_BAD_POS;
                        end else if (w_full) begin
                            n_res_status = olid_pkg::ST_FULL;
                        end else begin
                            w_cmd.op = olid_pkg::C_INSERT;
                            n_count  = r_count + 1'b1;
                        end
                    end
                    olid_pkg::REQ_DELETE: begin
                        if (w_pos >= w_cnt) begin
                            n_res_status = olid_pkg::ST_BAD_POS;
                        end else begin
                            w_cmd.op = olid_pkg::C_DELETE;
                            n_count  = r_count - 1'b1;
                        end
                    end
                    olid_pkg::REQ_FIND: begin
                        w_cmd.op = olid_pkg::C_FIND;
                        n_state  = olid_pkg::S_GROUP;
                    end
                    olid_pkg::REQ_CLEAR: begin
                        n_count = '0;
                    end
                    default: begin
                    end
                endcase
            end
            olid_pkg::S_GROUP: begin
                n_state = olid_pkg::S_PICK;
            end
            olid_pkg::S_PICK: begin
                if (w_hit) begin
                    n_res_status = olid_pkg::ST_OK;
                    n_res_found  = olid_pkg::FOUND_W'(w_hit_index);
                end else begin
                    n_res_status = olid_pkg::ST_NOT_FOUND;
                    n_res_found  = '0;
                end
                n_state = olid_pkg::S_OUT;
            end
            olid_pkg::S_OUT: begin
                // Wait here until the output register is free or being taken.
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_found  = r_res_found;
                    n_out_count  = r_count;
                    n_state      = olid_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = olid_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= olid_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req_type;
            r_pos <= i_position;
            r_val <= i_item_value;
        end
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_count  <= n_out_count;
    end

    genvar g;
    generate
        for (g = 0; g < olid_pkg::DEPTH; g++) begin : g_cell
            logic [olid_pkg::VALUE_WIDTH-1:0] w_prev;
            logic [olid_pkg::VALUE_WIDTH-1:0] w_next;
            if (g == 0) begin : g_first
                assign w_prev = '0;
            end else begin : g_mid_prev
                assign w_prev = w_value[g-1];
            end
            if (g == olid_pkg::DEPTH - 1) begin : g_last
                assign w_next = '0;
            end else begin : g_mid_next
                assign w_next = w_value[g+1];
            end
            olid_cell u_cell (
                .i_clk   (i_clk),
                .i_cmd   (w_cmd),
                .i_index (olid_pkg::CNT_W'(g)),
                .i_prev  (w_prev),
                .i_next  (w_next),
                .o_value (w_value[g]),
                .o_match (w_match[g])
            );
        end
    endgenerate

    olid_enc u_enc (
        .i_clk   (i_clk),
        .i_match (w_match),
        .o_hit   (w_hit),
        .o_index (w_hit_index)
    );

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_found_position = r_out_found;
    assign o_entry_count    = olid_pkg::ENTRY_W'(r_out_count);

endmodule

### sv/olid_cell.sv
// One list slot: holds an entry, shifts with its neighbors and compares for find.
// Depends on olid_pkg.
module olid_cell (
    input  logic                            i_clk,
    input  olid_pkg::t_cell_cmd             i_cmd,
    input  logic [olid_pkg::CNT_W-1:0]      i_index,
    input  logic [olid_pkg::VALUE_WIDTH-1:0] i_prev,
    input  logic [olid_pkg::VALUE_WIDTH-1:0] i_next,
    output logic [olid_pkg::VALUE_WIDTH-1:0] o_value,
    output logic                            o_match
);

    logic [olid_pkg::VALUE_WIDTH-1:0] r_value;
    logic [olid_pkg::VALUE_WIDTH-1:0] n_value;
    logic                             r_match;
    logic                             n_match;
    logic [olid_pkg::CMP_W-1:0]       w_idx;

    assign w_idx = olid_pkg::CMP_W'(i_index);

    always_comb begin
        n_value = r_value;
        n_match = 1'b0;
        unique case (i_cmd.op)
            olid_pkg::C_APPEND: begin
                if (i_index == i_cmd.count) begin
                    n_value = i_cmd.value;
                end
            end
            olid_pkg::C_INSERT: begin
                if (w_idx == i_cmd.pos) begin
                    n_value = i_cmd.value;
                end else if (w_idx > i_cmd.pos) begin
                    n_value = i_prev;
                end
            end
            olid_pkg::C_DELETE: begin
                if (w_idx >= i_cmd.pos) begin
                    n_value = i_next;
                end
            end
            olid_pkg::C_FIND: begin
                n_match = (i_index < i_cmd.count) && (r_value == i_cmd.value);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_match <= n_match;
    end

    assign o_value = r_value;
    assign o_match = r_match;

endmodule

### sv/olid_enc.sv
// Two-stage priority encoder that finds the lowest set match bit of the cell row.
// Stage one is registered per group of eight cells. Depends on olid_pkg.
module olid_enc (
    input  logic                          i_clk,
    input  logic [olid_pkg::DEPTH-1:0]    i_match,
    output logic                          o_hit,
    output logic [olid_pkg::IDX_W-1:0]    o_index
);

    logic [olid_pkg::PAD_W-1:0]    w_pad;
    logic [olid_pkg::NGRP-1:0]     r_grp_hit;
    logic [olid_pkg::NGRP-1:0]     n_grp_hit;
    logic [olid_pkg::LOC_W-1:0]    r_grp_loc [olid_pkg::NGRP];
    logic [olid_pkg::LOC_W-1:0]    n_grp_loc [olid_pkg::NGRP];
    logic [olid_pkg::GRP_W-1:0]    w_sel;

    assign w_pad = olid_pkg::PAD_W'(i_match);

    // Lowest set bit inside each group of eight.
    always_comb begin
        for (int g = 0; g < olid_pkg::NGRP; g++) begin
            n_grp_hit[g] = 1'b0;
            n_grp_loc[g] = '0;
            for (int j = olid_pkg::GRP_SZ - 1; j >= 0; j--) begin
                if (w_pad[g * olid_pkg::GRP_SZ + j]) begin
                    n_grp_hit[g] = 1'b1;
                    n_grp_loc[g] = olid_pkg::LOC_W'(j);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp_hit <= n_grp_hit;
        r_grp_loc <= n_grp_loc;
    end

    // Lowest group with a hit.
    always_comb begin
        w_sel = '0;
        for (int g = olid_pkg::NGRP - 1; g >= 0; g--) begin
            if (r_grp_hit[g]) begin
                w_sel = olid_pkg::GRP_W'(g);
            end
        end
    end

    assign o_hit   = |r_grp_hit;
    assign o_index = olid_pkg::IDX_W'({w_sel, r_grp_loc[w_sel]});

endmodule
